// ===== src/utf8v_pkg.sv =====
package utf8v_pkg;

	typedef enum logic [2:0] {
		V_OK       = 3'd0,
		V_BAD_UTF8 = 3'd1,
		V_TOO_LONG = 3'd2,
		V_BAD_CHAR = 3'd3,
		V_EMPTY    = 3'd4
	} verdict_t;

	typedef enum logic {
		MODE_HOSTNAME = 1'b0,
		MODE_PASSWORD = 1'b1
	} mode_t;

	localparam logic       REG_MODE      = 1'b0;
	localparam logic       REG_MAX_CHARS = 1'b1;
	localparam logic [7:0] MAX_CHARS_RST = 8'd63;

	localparam logic [30:0] CP_PRINT_LO = 31'h20;
	localparam logic [30:0] CP_PRINT_HI = 31'h7E;
	localparam logic [30:0] CP_DIGIT_LO = 31'h30;
	localparam logic [30:0] CP_DIGIT_HI = 31'h39;
	localparam logic [30:0] CP_UPPER_LO = 31'h41;
	localparam logic [30:0] CP_UPPER_HI = 31'h5A;
	localparam logic [30:0] CP_LOWER_LO = 31'h61;
	localparam logic [30:0] CP_LOWER_HI = 31'h7A;
	localparam logic [30:0] CP_USCORE   = 31'h5F;
	localparam logic [30:0] CP_CJK_LO   = 31'h4E00;
	localparam logic [30:0] CP_CJK_HI   = 31'h9FA5;

	typedef struct packed {
		logic [2:0]  pend;
		logic [30:0] acc;
		logic [8:0]  cnt;
		verdict_t    err;
		logic        seen;
	} utf8v_state_t;

	function automatic logic char_ok(input logic [30:0] cp, input mode_t mode);
		logic ok;
		if (mode == MODE_PASSWORD) begin
			ok = (cp >= CP_PRINT_LO) && (cp <= CP_PRINT_HI);
		end else begin
			ok = ((cp >= CP_DIGIT_LO) && (cp <= CP_DIGIT_HI)) ||
			     ((cp >= CP_UPPER_LO) && (cp <= CP_UPPER_HI)) ||
			     ((cp >= CP_LOWER_LO) && (cp <= CP_LOWER_HI)) ||
			     (cp == CP_USCORE) ||
			     ((cp >= CP_CJK_LO) && (cp <= CP_CJK_HI));
		end
		return ok;
	endfunction

endpackage

// ===== src/utf8v_step.sv =====
module utf8v_step import utf8v_pkg::*; (
	input  utf8v_state_t cur,
	input  logic [7:0]   data_byte,
	input  logic         has_byte,
	input  logic         last,
	input  mode_t        mode,
	input  logic [7:0]   max_chars,
	output utf8v_state_t nxt,
	output verdict_t     verdict,
	output logic [8:0]   char_count
);

	always_comb begin
		utf8v_state_t s;
		logic         fin;
		s   = cur;
		fin = 1'b0;
		if (has_byte) begin
			s.seen = 1'b1;
			if (cur.err == V_OK) begin
				if (cur.pend != 3'd0) begin
					if (data_byte[7:6] != 2'b10) begin
						s.err = V_BAD_UTF8;
					end else begin
						s.acc  = {cur.acc[24:0], data_byte[5:0]};
						s.pend = cur.pend - 3'd1;
						fin    = (cur.pend == 3'd1);
					end
				end else begin
					priority if (data_byte[7] == 1'b0) begin
						s.acc = {23'd0, data_byte};
						fin   = 1'b1;
					end else if (data_byte[7:5] == 3'b110) begin
						s.pend = 3'd1;
						s.acc  = {26'd0, data_byte[4:0]};
					end else if (data_byte[7:4] == 4'b1110) begin
						s.pend = 3'd2;
						s.acc  = {27'd0, data_byte[3:0]};
					end else if (data_byte[7:3] == 5'b11110) begin
						s.pend = 3'd3;
						s.acc  = {28'd0, data_byte[2:0]};
					end else if (data_byte[7:2] == 6'b111110) begin
						s.pend = 3'd4;
						s.acc  = {29'd0, data_byte[1:0]};
					end else if (data_byte[7:1] == 7'b1111110) begin
						s.pend = 3'd5;
						s.acc  = {30'd0, data_byte[0]};
					end else begin
						s.err = V_BAD_UTF8;
					end
				end
			end
		end
		if (fin) begin
			if (s.cnt <= {1'b0, max_chars}) begin
				s.cnt = s.cnt + 9'd1;
			end
			if (s.cnt > {1'b0, max_chars}) begin
				s.err = V_TOO_LONG;
			end else if (!char_ok(s.acc, mode)) begin
				s.err = V_BAD_CHAR;
			end
		end

		verdict    = s.err;
		char_count = s.cnt;
		nxt        = s;
		if (last) begin
			if (s.err == V_OK) begin
				if (!s.seen) begin
					verdict = V_EMPTY;
				end else if (s.pend != 3'd0) begin
					verdict = V_BAD_UTF8;
				end
			end
			nxt.pend = 3'd0;
			nxt.acc  = 31'd0;
			nxt.cnt  = 9'd0;
			nxt.err  = V_OK;
			nxt.seen = 1'b0;
		end
	end

endmodule

// ===== src/utf8_text_field_validator_unit.sv =====
// Validates a UTF-8 text field streamed one byte per beat. Bytes are decoded as original
// UTF-8 (sequences of 1 to 6 bytes, no overlong check), each character is counted and
// checked against the class set by mode (hostname set or printable ASCII), and the first
// error is kept. The beat marked last yields one result beat with the verdict and the
// saturating character count; other beats yield nothing. One beat is taken every cycle
// while the input does not stall: the decode step is combinational logic between the
// input register and the result register, and input stalls only while a result waits
// at the output untaken and another last beat is ready behind it in the input register.
// Register writes (index 0 mode, index 1 max_chars) are meant for idle periods.
module utf8_text_field_validator_unit import utf8v_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       has_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] verdict,
	output logic [8:0] char_count
);

	mode_t        mode_q;
	logic [7:0]   max_chars_q;
	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         has_s1;
	logic         last_s1;
	utf8v_state_t st_q;
	utf8v_state_t st_nxt;
	verdict_t     verdict_nxt;
	logic [8:0]   count_nxt;
	logic         out_valid_q;
	verdict_t     verdict_q;
	logic [8:0]   char_count_q;
	logic         adv;

	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_HOSTNAME;
			max_chars_q <= MAX_CHARS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:      mode_q      <= mode_t'(cfg_data[0]);
				REG_MAX_CHARS: max_chars_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			has_s1  <= has_byte;
			last_s1 <= last;
		end
	end

	utf8v_step u_step (
		.cur        (st_q),
		.data_byte  (data_s1),
		.has_byte   (has_s1),
		.last       (last_s1),
		.mode       (mode_q),
		.max_chars  (max_chars_q),
		.nxt        (st_nxt),
		.verdict    (verdict_nxt),
		.char_count (count_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.pend <= 3'd0;
			st_q.acc  <= 31'd0;
			st_q.cnt  <= 9'd0;
			st_q.err  <= V_OK;
			st_q.seen <= 1'b0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			verdict_q    <= verdict_nxt;
			char_count_q <= count_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign verdict    = verdict_q;
	assign char_count = char_count_q;

	// empty is only ever reported, never held across beats
	a_no_empty_latched: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.err != V_EMPTY)
		else $error("empty verdict latched in string state");

	a_ok_has_chars: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q == V_OK) |-> (char_count_q != 9'd0))
		else $error("ok verdict with no characters");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q == V_EMPTY) |-> (char_count_q == 9'd0))
		else $error("empty verdict with nonzero count");

	a_count_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.cnt != 9'd0) |-> st_q.seen)
		else $error("characters counted without a byte");

	a_state_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (st_q.cnt == 9'd0 && !st_q.seen && st_q.pend == 3'd0))
		else $error("string state not cleared after last beat");

endmodule
